// ===== rtl/wplh_pkg.sv =====
// ----------------------------------------------------------------------------
// wplh_pkg
// Shared types and constants of the windowed percentile level detector.
// ----------------------------------------------------------------------------
package wplh_pkg;

   localparam int WINDOW     = 2016;
   localparam int SEED_COUNT = 14;
   localparam int SEED_EFF   = (SEED_COUNT > WINDOW) ? WINDOW : SEED_COUNT;
   localparam int SLOT_W     = $clog2(WINDOW);
   localparam int FILL_W     = $clog2(WINDOW + 1);
   localparam int RATE_W     = 32;
   localparam int PCT_W      = 7;
   localparam int SEED_VALUE = 253;
   localparam int QDEPTH     = 2;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_INIT   = 2'd1,
      REQ_STATUS = 2'd2,
      REQ_SPARE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_FALL_PCT = 2'd0,
      CSR_MID_PCT  = 2'd1,
      CSR_RISE_PCT = 2'd2,
      CSR_FALLBACK = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              push;
      logic              init;
      logic [RATE_W-1:0] rate;
   } cmd_type;

endpackage

// ===== rtl/wplh_ram.sv =====
// ----------------------------------------------------------------------------
// wplh_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module wplh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/wplh_front.sv =====
// ----------------------------------------------------------------------------
// wplh_front
// Accepts request words, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module wplh_front import wplh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [RATE_W-1:0] rate_sample,
   output logic              cmd_valid,
   output cmd_type           cmd,
   input  logic              cmd_take
);
   localparam int PTR_W = $clog2(QDEPTH);
   cmd_type          queue_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             req_take;
   cmd_type          cmd_new;

   assign req_stall = (count_ff == (PTR_W+1)'(QDEPTH));
   assign req_take  = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      cmd_new.push = 1'b0;
      cmd_new.init = 1'b0;
      cmd_new.rate = rate_sample;
      unique case (req_code_type'(req_type))
         REQ_SAMPLE: cmd_new.push = 1'b1;
         REQ_INIT:   cmd_new.init = 1'b1;
         default:    ;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(req_take);
      rd_ptr_in = rd_ptr_ff + PTR_W'(cmd_take);
      count_in  = count_ff + (PTR_W+1)'(req_take) - (PTR_W+1)'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (req_take) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end
endmodule

// ===== rtl/wplh_back.sv =====
// ----------------------------------------------------------------------------
// wplh_back
// Executes commands: window update, bitwise rank selection, hysteresis.
// ----------------------------------------------------------------------------
module wplh_back import wplh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_take,
   input  logic [PCT_W-1:0]  fall_pct,
   input  logic [PCT_W-1:0]  mid_pct,
   input  logic [PCT_W-1:0]  rise_pct,
   input  logic [RATE_W-1:0] fallback,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              low_mode,
   output logic [RATE_W-1:0] fall_threshold,
   output logic [RATE_W-1:0] mid_threshold,
   output logic [RATE_W-1:0] rise_threshold,
   output logic [RATE_W-1:0] last_rate,
   output logic              last_rate_valid,
   output logic [FILL_W-1:0] window_fill
);
   localparam int BIT_W  = $clog2(RATE_W);
   localparam int PROD_W = FILL_W + PCT_W;
   localparam int RANK_W = FILL_W;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_WRITE = 8'b0000_0010,
      ST_RANK  = 8'b0000_0100,
      ST_SCAN  = 8'b0000_1000,
      ST_DRAIN = 8'b0001_0000,
      ST_BIT   = 8'b0010_0000,
      ST_JUDGE = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              low_ff, low_in;
   logic [RATE_W-1:0] recent_ff, recent_in;
   logic              recent_v_ff, recent_v_in;
   cmd_type           cur_ff, cur_in;
   logic [1:0]        sel_ff, sel_in;
   logic [RANK_W-1:0] rank_ff [3];
   logic [RANK_W-1:0] rank_in [3];
   logic [RATE_W-1:0] pre_ff [3];
   logic [RATE_W-1:0] pre_in [3];
   logic [RANK_W-1:0] cnt_ff [3];
   logic [RANK_W-1:0] cnt_in [3];
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rd_v_ff, rd_v_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [RATE_W-1:0] thr_ff [3];
   logic [RATE_W-1:0] thr_in [3];
   logic              rsp_v_ff, rsp_v_in;

   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [RATE_W-1:0] rd_data;
   logic [RATE_W-1:0] seed_word;
   logic              seed_hit;
   logic [RATE_W-1:0] sample_word;
   logic [PCT_W-1:0]  pct_sel;
   logic              last_bit;

   function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] a,
                                                  logic [FILL_W-1:0] b);
      logic [FILL_W:0] s;
      s = FILL_W'(a) + b;
      if (s >= (FILL_W+1)'(WINDOW)) begin
         s = s - (FILL_W+1)'(WINDOW);
      end
      return s[SLOT_W-1:0];
   endfunction

   // Seed entries are never written at reset: hold them in logic until
   // overwritten, tracked by a per-seed-slot written mark.
   logic [SEED_EFF:0] seed_ok_ff, seed_ok_in;

   wplh_ram #(.WIDTH(RATE_W), .DEPTH(WINDOW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cur_ff.rate),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   logic [SLOT_W-1:0] rd_slot_ff;
   assign seed_word   = RATE_W'(SEED_VALUE);
   assign seed_hit    = (FILL_W'(rd_slot_ff) < FILL_W'(SEED_EFF)) &&
                        !seed_ok_ff[rd_slot_ff[$clog2(SEED_EFF+1)-1:0]];
   assign sample_word = seed_hit ? seed_word : rd_data;
   assign wr_en       = (state_ff == ST_WRITE) && cur_ff.push;
   assign wr_addr     = (fill_ff < FILL_W'(WINDOW)) ? slot_add(oldest_ff, fill_ff) : oldest_ff;
   assign last_bit    = (bit_ff == '0);

   always_comb begin
      unique case (sel_ff)
         2'd0:    pct_sel = fall_pct;
         2'd1:    pct_sel = mid_pct;
         default: pct_sel = rise_pct;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      oldest_in   = oldest_ff;
      fill_in     = fill_ff;
      low_in      = low_ff;
      recent_in   = recent_ff;
      recent_v_in = recent_v_ff;
      cur_in      = cur_ff;
      sel_in      = sel_ff;
      rank_in     = rank_ff;
      pre_in      = pre_ff;
      cnt_in      = cnt_ff;
      bit_in      = bit_ff;
      idx_in      = idx_ff;
      slot_in     = slot_ff;
      rd_v_in     = 1'b0;
      prod_in     = prod_ff;
      thr_in      = thr_ff;
      rsp_v_in    = rsp_v_ff;
      seed_ok_in  = seed_ok_ff;
      cmd_take    = 1'b0;
      if (rsp_v_ff && !rsp_stall) begin
         rsp_v_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cur_in   = cmd;
               sel_in   = 2'd0;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (cur_ff.push || cur_ff.init) begin
               recent_in   = cur_ff.rate;
               recent_v_in = 1'b1;
            end
            if (cur_ff.push) begin
               if (FILL_W'(wr_addr) < FILL_W'(SEED_EFF)) begin
                  seed_ok_in[wr_addr[$clog2(SEED_EFF+1)-1:0]] = 1'b1;
               end
               if (fill_ff < FILL_W'(WINDOW)) begin
                  fill_in = fill_ff + 1'b1;
               end else if (FILL_W'(oldest_ff) == FILL_W'(WINDOW - 1)) begin
                  oldest_in = '0;
               end else begin
                  oldest_in = oldest_ff + 1'b1;
               end
            end
            sel_in   = 2'd0;
            prod_in  = PROD_W'(fill_in) * PROD_W'(pct_sel);
            state_in = ST_RANK;
         end
         ST_RANK: begin
            // rank = floor(n*p/100), clamped to n-1, by repeated subtraction
            if (prod_ff >= PROD_W'(100) && rank_ff[sel_ff] < fill_ff) begin
               prod_in = prod_ff - PROD_W'(100);
               rank_in[sel_ff] = rank_ff[sel_ff] + 1'b1;
            end else begin
               if (rank_ff[sel_ff] >= fill_ff && fill_ff != '0) begin
                  rank_in[sel_ff] = fill_ff - 1'b1;
               end
               if (sel_ff == 2'd2) begin
                  if (fill_ff == '0) begin
                     for (int t = 0; t < 3; t++) thr_in[t] = fallback;
                     state_in = ST_JUDGE;
                  end else begin
                     bit_in   = BIT_W'(RATE_W - 1);
                     for (int t = 0; t < 3; t++) begin
                        pre_in[t] = '0;
                        cnt_in[t] = '0;
                     end
                     idx_in   = '0;
                     slot_in  = oldest_ff;
                     state_in = ST_SCAN;
                  end
               end else begin
                  sel_in  = sel_ff + 1'b1;
                  unique case (sel_ff)
                     2'd0:    prod_in = PROD_W'(fill_ff) * PROD_W'(mid_pct);
                     default: prod_in = PROD_W'(fill_ff) * PROD_W'(rise_pct);
                  endcase
               end
            end
         end
         ST_SCAN: begin
            rd_v_in = 1'b1;
            idx_in  = idx_ff + 1'b1;
            slot_in = (FILL_W'(slot_ff) == FILL_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
            if (idx_ff + 1'b1 == fill_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_BIT;
         end
         ST_BIT: begin
            for (int t = 0; t < 3; t++) begin
               if (rank_ff[t] >= cnt_ff[t]) begin
                  rank_in[t] = rank_ff[t] - cnt_ff[t];
                  pre_in[t]  = pre_ff[t] | (RATE_W'(1) << bit_ff);
               end
               cnt_in[t] = '0;
            end
            if (last_bit) begin
               for (int t = 0; t < 3; t++) thr_in[t] = pre_in[t];
               state_in = ST_JUDGE;
            end else begin
               bit_in   = bit_ff - 1'b1;
               idx_in   = '0;
               slot_in  = oldest_ff;
               state_in = ST_SCAN;
            end
         end
         ST_JUDGE: begin
            if (cur_ff.push) begin
               if (low_ff) begin
                  if (cur_ff.rate > thr_ff[2]) low_in = 1'b0;
               end else if (cur_ff.rate <= thr_ff[0]) begin
                  low_in = 1'b1;
               end
            end else if (cur_ff.init) begin
               low_in = (cur_ff.rate < thr_ff[1]);
            end
            for (int t = 0; t < 3; t++) rank_in[t] = '0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_v_ff) begin
               rsp_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (rd_v_ff) begin
         for (int t = 0; t < 3; t++) begin
            if ((sample_word >> bit_ff) == (pre_ff[t] >> bit_ff)) begin
               cnt_in[t] = cnt_ff[t] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         oldest_ff   <= '0;
         fill_ff     <= FILL_W'(SEED_EFF);
         low_ff      <= 1'b0;
         recent_ff   <= '0;
         recent_v_ff <= 1'b0;
         rsp_v_ff    <= 1'b0;
         rd_v_ff     <= 1'b0;
         seed_ok_ff  <= '0;
         for (int t = 0; t < 3; t++) rank_ff[t] <= '0;
      end else begin
         state_ff    <= state_in;
         oldest_ff   <= oldest_in;
         fill_ff     <= fill_in;
         low_ff      <= low_in;
         recent_ff   <= recent_in;
         recent_v_ff <= recent_v_in;
         rsp_v_ff    <= rsp_v_in;
         rd_v_ff     <= rd_v_in;
         seed_ok_ff  <= seed_ok_in;
         rank_ff     <= rank_in;
      end
      cur_ff     <= cur_in;
      sel_ff     <= sel_in;
      pre_ff     <= pre_in;
      cnt_ff     <= cnt_in;
      bit_ff     <= bit_in;
      idx_ff     <= idx_in;
      slot_ff    <= slot_in;
      rd_slot_ff <= slot_ff;
      prod_ff    <= prod_in;
      thr_ff     <= thr_in;
      if (state_ff == ST_OUT && !rsp_v_ff) begin
         low_mode        <= low_ff;
         fall_threshold  <= thr_ff[0];
         mid_threshold   <= thr_ff[1];
         rise_threshold  <= thr_ff[2];
         last_rate       <= recent_v_ff ? recent_ff : '0;
         last_rate_valid <= recent_v_ff;
         window_fill     <= fill_ff;
      end
   end

   assign rsp_valid = rsp_v_ff;
endmodule

// ===== rtl/window_percentile_level_hysteresis_top.sv =====
// ----------------------------------------------------------------------------
// window_percentile_level_hysteresis_top
// Sliding-window percentile thresholds with a hysteresis low/high flag.
// ----------------------------------------------------------------------------
// Each request word yields one response word. For a window of n samples a
// command first derives the three ranks by repeated subtraction, one
// subtraction for every hundred in n * p for each of the three percentiles p
// (capped at n each). The bitwise rank selection that follows reads the window
// RAM once per result bit for all three thresholds together and dominates.
// A two-entry queue decouples request intake from the executing back end, and
// the response register lets the next command start while a response waits.
module window_percentile_level_hysteresis_top import wplh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [RATE_W-1:0] rate_sample,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              low_mode,
   output logic [RATE_W-1:0] fall_threshold,
   output logic [RATE_W-1:0] mid_threshold,
   output logic [RATE_W-1:0] rise_threshold,
   output logic [RATE_W-1:0] last_rate,
   output logic              last_rate_valid,
   output logic [FILL_W-1:0] window_fill,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [RATE_W-1:0] csr_data
);
   logic [PCT_W-1:0]  fall_pct_ff, mid_pct_ff, rise_pct_ff;
   logic [RATE_W-1:0] fallback_ff;
   logic              cmd_valid, cmd_take;
   cmd_type           cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         fall_pct_ff <= PCT_W'(17);
         mid_pct_ff  <= PCT_W'(20);
         rise_pct_ff <= PCT_W'(23);
         fallback_ff <= RATE_W'(SEED_VALUE);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FALL_PCT: fall_pct_ff <= csr_data[PCT_W-1:0];
            CSR_MID_PCT:  mid_pct_ff  <= csr_data[PCT_W-1:0];
            CSR_RISE_PCT: rise_pct_ff <= csr_data[PCT_W-1:0];
            CSR_FALLBACK: fallback_ff <= csr_data;
            default:      ;
         endcase
      end
   end

   wplh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .rate_sample (rate_sample),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   wplh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take),
      .fall_pct        (fall_pct_ff),
      .mid_pct         (mid_pct_ff),
      .rise_pct        (rise_pct_ff),
      .fallback        (fallback_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .low_mode        (low_mode),
      .fall_threshold  (fall_threshold),
      .mid_threshold   (mid_threshold),
      .rise_threshold  (rise_threshold),
      .last_rate       (last_rate),
      .last_rate_valid (last_rate_valid),
      .window_fill     (window_fill)
   );

   a_take_needs_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("command taken from empty queue");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      window_fill <= FILL_W'(WINDOW)) else $error("window fill beyond depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(window_fill))
      else $error("stalled response lost");
endmodule
